@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle.
`define DSRV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define DSRV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/dsrv_pkg.sv @@
// ----------------------------------------------------------------------------
// dsrv_pkg
// Types, constants and the CRC-32 word update shared by the validator.
// ----------------------------------------------------------------------------
package dsrv_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] ALL_ONES      = 32'hFFFFFFFF;
    localparam logic [31:0] MAGIC_WORD    = 32'h43414C31;
    localparam logic [31:0] COMMIT_WORD   = 32'hC0A17ED1;
    localparam logic [15:0] FORMAT_VER    = 16'd1;
    localparam logic [15:0] PAYLOAD_BYTES = 16'd28;

    localparam logic [3:0] POS_MAGIC  = 4'd0;
    localparam logic [3:0] POS_HEADER = 4'd1;
    localparam logic [3:0] POS_GEN    = 4'd2;
    localparam logic [3:0] POS_CRC    = 4'd10;
    localparam logic [3:0] POS_COMMIT = 4'd11;

    localparam logic [2:0] CAUSE_OK      = 3'd0;
    localparam logic [2:0] CAUSE_MAGIC   = 3'd1;
    localparam logic [2:0] CAUSE_VERSION = 3'd2;
    localparam logic [2:0] CAUSE_SIZE    = 3'd3;
    localparam logic [2:0] CAUSE_CRC     = 3'd4;
    localparam logic [2:0] CAUSE_COMMIT  = 3'd5;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_SELECT  = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [2:0]  cause;
        logic        slot;
        logic [31:0] gen;
    } t_q_entry;

    typedef struct packed {
        logic        save_slot;
        logic [31:0] next_generation;
        logic        found_valid;
        logic [31:0] generation;
        logic        slot_number;
        logic [2:0]  fail_cause;
        logic        record_ok;
    } t_result;

    // Reflected CRC-32 over one word fed least significant byte first.
    function automatic logic [31:0] crc_word(input logic [31:0] c_in,
                                             input logic [31:0] w);
        logic [31:0] c;
        c = c_in ^ w;
        for (int k = 0; k < 32; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/dual_slot_record_validator.sv @@
// ----------------------------------------------------------------------------
// dual_slot_record_validator
// Checks 12-word records from two slots and selects the newest valid one.
//
//   Channel  Dir  Handshake              Content
//   s_*      in   i_s_tvalid/o_s_tready  record word or end of scan
//   m_*      out  o_m_tvalid/i_m_tready  record verdict or scan selection
//
// One input item is taken per cycle while the queue is not full; the CRC update
// of a word is one unrolled step in the front. A result goes from the accepting
// edge into the queue and then into the output register before it is valid.
// A four-entry queue and the output register let either side stall alone.
// Synchronous active-low reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module dual_slot_record_validator #(
    parameter int QUEUE_DEPTH = dsrv_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [0] slot_id, [32:1] record_word, [39:33] zero
    input  logic [39:0] i_s_tdata,
    // [0] command
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] record_ok, [3:1] fail_cause, [4] slot_number, [36:5] generation,
    // [37] found_valid, [69:38] next_generation, [70] save_slot, [71] zero
    output logic [71:0] o_m_tdata,
    // [0] result_kind
    output logic        o_m_tuser
);

`include "assert_macros.svh"

    logic               w_push;
    logic               w_full;
    logic               w_q_valid;
    logic               w_pop;
    dsrv_pkg::t_q_entry w_push_entry;
    dsrv_pkg::t_q_entry w_q_entry;
    dsrv_pkg::t_result  w_result;

    dsrv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_slot     (i_s_tdata[0]),
        .i_word     (i_s_tdata[32:1]),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    dsrv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_pop   (w_pop)
    );

    dsrv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_entry  (w_q_entry),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_kind     (o_m_tuser),
        .o_result   (w_result)
    );

    assign o_m_tdata = {1'b0, w_result};

    `DSRV_ASSERT_NEXT(a_queue_keeps_entry, w_q_valid && !w_pop, w_q_valid,
        "queue lost an entry that was not popped")

    `DSRV_ASSERT_SAME(a_verdict_ok_matches_cause,
        o_m_tvalid && (o_m_tuser == dsrv_pkg::KIND_VERDICT),
        o_m_tdata[0] == (o_m_tdata[3:1] == dsrv_pkg::CAUSE_OK),
        "verdict ok flag disagrees with fail cause")

    `DSRV_ASSERT_SAME(a_empty_scan_defaults,
        o_m_tvalid && (o_m_tuser == dsrv_pkg::KIND_SELECT) && !o_m_tdata[37],
        (o_m_tdata[69:38] == 32'd1) && !o_m_tdata[70] && !o_m_tdata[4],
        "selection without a valid slot has wrong defaults")

    `DSRV_ASSERT_NEXT(a_push_fills_queue, w_push && !w_full, w_q_valid,
        "queue empty after a push")

endmodule

@@ hdl/dsrv_front.sv @@
// ----------------------------------------------------------------------------
// dsrv_front
// Accepts items, tracks the word position, runs the CRC and format checks,
// and queues one entry per completed record or end of scan.
// ----------------------------------------------------------------------------
module dsrv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic                i_cmd,
    input  logic                i_slot,
    input  logic [31:0]         i_word,
    input  logic                i_q_full,
    output logic                o_push,
    output dsrv_pkg::t_q_entry  o_entry
);

    logic [3:0]  r_pos,  n_pos;
    logic [31:0] r_crc,  n_crc;
    logic [2:0]  r_fail, n_fail;
    logic [31:0] r_gen,  n_gen;

    logic        w_accept;
    logic [2:0]  w_cause;
    logic [2:0]  w_fail;

    assign o_s_tready = !i_q_full;
    assign w_accept   = i_s_tvalid && !i_q_full;

    always_comb begin
        w_cause = dsrv_pkg::CAUSE_OK;
        case (r_pos)
            dsrv_pkg::POS_MAGIC: begin
                if (i_word != dsrv_pkg::MAGIC_WORD) w_cause = dsrv_pkg::CAUSE_MAGIC;
            end
            dsrv_pkg::POS_HEADER: begin
                if (i_word[15:0] != dsrv_pkg::FORMAT_VER) begin
                    w_cause = dsrv_pkg::CAUSE_VERSION;
                end else if (i_word[31:16] != dsrv_pkg::PAYLOAD_BYTES) begin
                    w_cause = dsrv_pkg::CAUSE_SIZE;
                end
            end
            dsrv_pkg::POS_CRC: begin
                if (i_word != (r_crc ^ dsrv_pkg::ALL_ONES)) w_cause = dsrv_pkg::CAUSE_CRC;
            end
            dsrv_pkg::POS_COMMIT: begin
                if (i_word != dsrv_pkg::COMMIT_WORD) w_cause = dsrv_pkg::CAUSE_COMMIT;
            end
            default: w_cause = dsrv_pkg::CAUSE_OK;
        endcase
    end

    assign w_fail = (r_fail != dsrv_pkg::CAUSE_OK) ? r_fail : w_cause;

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_fail  = r_fail;
        n_gen   = r_gen;
        o_push  = 1'b0;
        o_entry = '0;
        if (w_accept) begin
            if (i_cmd == dsrv_pkg::KIND_SELECT) begin
                o_push       = 1'b1;
                o_entry.kind = dsrv_pkg::KIND_SELECT;
                n_pos        = '0;
                n_crc        = dsrv_pkg::ALL_ONES;
                n_fail       = dsrv_pkg::CAUSE_OK;
                n_gen        = '0;
            end else if (r_pos >= dsrv_pkg::POS_COMMIT) begin
                o_push        = 1'b1;
                o_entry.kind  = dsrv_pkg::KIND_VERDICT;
                o_entry.ok    = (w_fail == dsrv_pkg::CAUSE_OK);
                o_entry.cause = w_fail;
                o_entry.slot  = i_slot;
                o_entry.gen   = r_gen;
                n_pos         = '0;
                n_crc         = dsrv_pkg::ALL_ONES;
                n_fail        = dsrv_pkg::CAUSE_OK;
                n_gen         = '0;
            end else begin
                n_fail = w_fail;
                n_pos  = r_pos + 4'd1;
                if (r_pos == dsrv_pkg::POS_GEN) n_gen = i_word;
                if (r_pos >= dsrv_pkg::POS_HEADER && r_pos < dsrv_pkg::POS_CRC) begin
                    n_crc = dsrv_pkg::crc_word(r_crc, i_word);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= dsrv_pkg::ALL_ONES;
            r_fail <= dsrv_pkg::CAUSE_OK;
            r_gen  <= '0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_fail <= n_fail;
            r_gen  <= n_gen;
        end
    end

endmodule

@@ hdl/dsrv_queue.sv @@
// ----------------------------------------------------------------------------
// dsrv_queue
// Small register FIFO that decouples the checking front from the back end.
// ----------------------------------------------------------------------------
module dsrv_queue #(
    parameter int DEPTH = dsrv_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dsrv_pkg::t_q_entry  i_entry,
    output logic                o_full,
    output logic                o_valid,
    output dsrv_pkg::t_q_entry  o_entry,
    input  logic                i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dsrv_pkg::t_q_entry r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_valid   = (r_count != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        if (w_do_pop)  n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        if (w_do_push && !w_do_pop) n_count = r_count + CNT_W'(1);
        if (!w_do_push && w_do_pop) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

@@ hdl/dsrv_back.sv @@
// ----------------------------------------------------------------------------
// dsrv_back
// Keeps the newest valid slot of the scan and forms the registered results.
// ----------------------------------------------------------------------------
module dsrv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  dsrv_pkg::t_q_entry  i_q_entry,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic                o_kind,
    output dsrv_pkg::t_result   o_result
);

    logic               r_any,  n_any;
    logic               r_best_slot, n_best_slot;
    logic [31:0]        r_best_gen,  n_best_gen;
    logic               r_out_valid, n_out_valid;
    logic               r_out_kind,  n_out_kind;
    dsrv_pkg::t_result  r_out,  n_out;
    logic [31:0]        w_diff;
    logic               w_newer;

    assign o_pop      = i_q_valid && (!r_out_valid || i_m_tready);
    assign w_diff     = i_q_entry.gen - r_best_gen;
    assign w_newer    = (w_diff != '0) && !w_diff[31];
    assign o_m_tvalid = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_result   = r_out;

    always_comb begin
        n_any       = r_any;
        n_best_slot = r_best_slot;
        n_best_gen  = r_best_gen;
        n_out_kind  = r_out_kind;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        if (o_pop) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out_kind  = i_q_entry.kind;
            if (i_q_entry.kind == dsrv_pkg::KIND_SELECT) begin
                n_out.found_valid     = r_any;
                n_out.slot_number     = r_any ? r_best_slot : 1'b0;
                n_out.generation      = r_any ? r_best_gen : '0;
                n_out.next_generation = (r_any && r_best_gen != '0) ?
                                        r_best_gen + 32'd1 : 32'd1;
                n_out.save_slot       = r_any ? !r_best_slot : 1'b0;
                n_any       = 1'b0;
                n_best_slot = 1'b0;
                n_best_gen  = '0;
            end else begin
                n_out.record_ok   = i_q_entry.ok;
                n_out.fail_cause  = i_q_entry.cause;
                n_out.slot_number = i_q_entry.slot;
                n_out.generation  = i_q_entry.gen;
                if (i_q_entry.ok && (!r_any || w_newer)) begin
                    n_any       = 1'b1;
                    n_best_slot = i_q_entry.slot;
                    n_best_gen  = i_q_entry.gen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any       <= 1'b0;
            r_best_slot <= 1'b0;
            r_best_gen  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_any       <= n_any;
            r_best_slot <= n_best_slot;
            r_best_gen  <= n_best_gen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out      <= n_out;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for dual_slot_record_validator
// The testbench streams 12-word records from both slots, with faults in every
// check, truncated records, stray words and end-of-scan commands, under bursty
// input traffic and a stalling output. An internal model predicts each verdict
// and selection. Every output item is compared field by field against the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_RECORD_WORD = 1'b0;
    localparam logic CMD_SCAN_END    = 1'b1;

    localparam int unsigned TOTAL_ITEMS    = 1700;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned TAIL_CYCLES    = 8;
    localparam int unsigned MAX_PRINTS     = 100;
    localparam int          DIR_ROWS       = 19;

    typedef enum logic [1:0] {WORD_RAW, WORD_CRC_GOOD, WORD_CRC_BAD} t_word_mode;
    typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_RANDOM} t_rx_mode;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [2:0]  cause;
        logic        slot;
        logic [31:0] gen;
        logic        found;
        logic [31:0] next_gen;
        logic        target;
    } t_outcome;

    typedef struct packed {
        logic        cmd;
        logic        slot;
        logic [31:0] word;
        t_word_mode  mode;
        logic        drain;
        logic        has_exp;
        t_outcome    exp;
    } t_stim;

    localparam t_outcome EXP_NONE = '0;
    localparam t_outcome EXP_EMPTY_SCAN =
        '{dsrv_pkg::KIND_SELECT, 1'b0, dsrv_pkg::CAUSE_OK, 1'b0, 32'd0, 1'b0, 32'd1, 1'b0};
    localparam t_outcome EXP_TOP_VERDICT =
        '{dsrv_pkg::KIND_VERDICT, 1'b1, dsrv_pkg::CAUSE_OK, 1'b1, 32'hFFFFFFFF, 1'b0,
          32'd0, 1'b0};
    localparam t_outcome EXP_TOP_SCAN =
        '{dsrv_pkg::KIND_SELECT, 1'b0, dsrv_pkg::CAUSE_OK, 1'b1, 32'hFFFFFFFF, 1'b1,
          32'd0, 1'b0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic        o_m_tuser;

    dual_slot_record_validator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [31:0] crc_run = dsrv_pkg::ALL_ONES;
    logic [3:0]  word_pos = '0;
    logic [2:0]  first_bad = dsrv_pkg::CAUSE_OK;
    logic [31:0] rec_gen = '0;
    logic        any_valid = 1'b0;
    logic        best_slot_q = 1'b0;
    logic [31:0] best_gen_q = '0;

    t_outcome    pending_q[$];
    t_stim       stim_q[$];
    t_stim       dir_tbl[DIR_ROWS];
    logic        drv_has_exp = 1'b0;
    t_outcome    drv_exp = '0;
    int unsigned items_in = 0;
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    logic [31:0] last_gen = '0;

    function automatic logic [31:0] crc32_word(input logic [31:0] c, input logic [31:0] w);
        logic [31:0] acc;
        acc = c;
        for (int b = 0; b < 4; b++) begin
            acc ^= {24'd0, w[8*b +: 8]};
            for (int k = 0; k < 8; k++) begin
                acc = acc[0] ? ((acc >> 1) ^ dsrv_pkg::CRC_POLY) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    function automatic void clear_record();
        crc_run   = dsrv_pkg::ALL_ONES;
        word_pos  = '0;
        first_bad = dsrv_pkg::CAUSE_OK;
        rec_gen   = '0;
    endfunction

    function automatic void note_cause(input logic [2:0] cause);
        if (first_bad == dsrv_pkg::CAUSE_OK) begin
            first_bad = cause;
        end
    endfunction

    function automatic bit predict_outcome(input logic cmd, input logic slot,
                                           input logic [31:0] w, output t_outcome r);
        logic [31:0] diff;
        r = '0;
        if (cmd == CMD_SCAN_END) begin
            r.kind     = dsrv_pkg::KIND_SELECT;
            r.next_gen = 32'd1;
            if (any_valid) begin
                r.slot   = best_slot_q;
                r.gen    = best_gen_q;
                r.found  = 1'b1;
                r.target = ~best_slot_q;
                if (best_gen_q != 32'd0) begin
                    r.next_gen = best_gen_q + 32'd1;
                end
            end
            clear_record();
            any_valid   = 1'b0;
            best_slot_q = 1'b0;
            best_gen_q  = '0;
            return 1'b1;
        end
        case (word_pos)
            dsrv_pkg::POS_MAGIC: begin
                if (w != dsrv_pkg::MAGIC_WORD) note_cause(dsrv_pkg::CAUSE_MAGIC);
            end
            dsrv_pkg::POS_HEADER: begin
                if (w[15:0] != dsrv_pkg::FORMAT_VER) note_cause(dsrv_pkg::CAUSE_VERSION);
                else if (w[31:16] != dsrv_pkg::PAYLOAD_BYTES) note_cause(dsrv_pkg::CAUSE_SIZE);
            end
            dsrv_pkg::POS_GEN: begin
                rec_gen = w;
            end
            dsrv_pkg::POS_CRC: begin
                if (w != ~crc_run) note_cause(dsrv_pkg::CAUSE_CRC);
            end
            dsrv_pkg::POS_COMMIT: begin
                if (w != dsrv_pkg::COMMIT_WORD) note_cause(dsrv_pkg::CAUSE_COMMIT);
            end
            default: ;
        endcase
        if (word_pos >= 4'd1 && word_pos <= 4'd9) begin
            crc_run = crc32_word(crc_run, w);
        end
        if (word_pos == dsrv_pkg::POS_COMMIT) begin
            r.kind  = dsrv_pkg::KIND_VERDICT;
            r.ok    = (first_bad == dsrv_pkg::CAUSE_OK);
            r.cause = first_bad;
            r.slot  = slot;
            r.gen   = rec_gen;
            diff    = rec_gen - best_gen_q;
            if (r.ok && (!any_valid || (diff != 32'd0 && !diff[31]))) begin
                any_valid   = 1'b1;
                best_slot_q = slot;
                best_gen_q  = rec_gen;
            end
            clear_record();
            return 1'b1;
        end
        word_pos = word_pos + 4'd1;
        return 1'b0;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic check_outcome(input t_outcome want);
        compare_field("result_kind", {31'd0, o_m_tuser}, {31'd0, want.kind});
        compare_field("record_ok", {31'd0, o_m_tdata[0]}, {31'd0, want.ok});
        compare_field("fail_cause", {29'd0, o_m_tdata[3:1]}, {29'd0, want.cause});
        compare_field("slot_number", {31'd0, o_m_tdata[4]}, {31'd0, want.slot});
        compare_field("generation", o_m_tdata[36:5], want.gen);
        compare_field("found_valid", {31'd0, o_m_tdata[37]}, {31'd0, want.found});
        compare_field("next_generation", o_m_tdata[69:38], want.next_gen);
        compare_field("save_slot", {31'd0, o_m_tdata[70]}, {31'd0, want.target});
    endtask

    always @(posedge i_clk) begin
        t_outcome pred;
        t_outcome want;
        if (!i_rst_n) begin
            clear_record();
            any_valid   = 1'b0;
            best_slot_q = 1'b0;
            best_gen_q  = '0;
            idle_cycles = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (predict_outcome(i_s_tuser, i_s_tdata[0], i_s_tdata[32:1], pred)) begin
                    pending_q.push_back(drv_has_exp ? drv_exp : pred);
                end
                items_in <= items_in + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_q.size() == 0) begin
                    report_error("output item arrived with nothing expected");
                end else begin
                    want = pending_q.pop_front();
                    check_outcome(want);
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("** dual_slot_record_validator: FAILED **");
                    $finish;
                end
            end
        end
    end

    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;
    logic [15:0] rx_mask = 16'h0001;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(32, 256);
            rx_mask = 16'($urandom) | 16'h0001;
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:    i_m_tready <= 1'b1;
            RX_PATTERN: begin
                i_m_tready <= rx_mask[0];
                rx_mask = {rx_mask[0], rx_mask[15:1]};
            end
            default:    i_m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic push_item(input logic cmd, input logic slot, input logic [31:0] w,
                             input t_word_mode mode, input logic drain);
        t_stim it;
        it       = '0;
        it.cmd   = cmd;
        it.slot  = slot;
        it.word  = w;
        it.mode  = mode;
        it.drain = drain;
        stim_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_gen();
        logic [31:0] g;
        case ($urandom_range(0, 11))
            0:       g = 32'd0;
            1:       g = 32'hFFFFFFFF;
            2:       g = 32'h7FFFFFFF;
            3:       g = 32'h80000000;
            4:       g = last_gen + 32'd1;
            5:       g = last_gen + 32'h7FFFFFFF;
            6:       g = last_gen + 32'h80000000;
            7:       g = last_gen + 32'h80000001;
            8:       g = last_gen - 32'd1;
            9:       g = last_gen;
            default: g = $urandom;
        endcase
        last_gen = g;
        return g;
    endfunction

    task automatic add_record(input logic commit_slot, input bit faulty, input int keep,
                              input logic drain);
        logic [31:0] words[12];
        t_word_mode  modes[12];
        logic [4:0]  faults;
        for (int i = 0; i < 12; i++) begin
            words[i] = rand_word();
            modes[i] = WORD_RAW;
        end
        words[0]  = dsrv_pkg::MAGIC_WORD;
        words[1]  = {dsrv_pkg::PAYLOAD_BYTES, dsrv_pkg::FORMAT_VER};
        words[2]  = pick_gen();
        modes[10] = WORD_CRC_GOOD;
        words[11] = dsrv_pkg::COMMIT_WORD;
        faults    = faulty ? 5'($urandom_range(1, 31)) : 5'd0;
        if (faults[0]) begin
            words[0] = $urandom_range(0, 1)
                       ? (dsrv_pkg::MAGIC_WORD ^ (32'h1 << $urandom_range(0, 31)))
                       : $urandom;
        end
        if (faults[1]) begin
            words[1][15:0] = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
            if ($urandom_range(0, 1)) words[1][31:16] = 16'($urandom);
        end
        if (faults[2]) begin
            words[1][31:16] = dsrv_pkg::PAYLOAD_BYTES ^ 16'($urandom_range(1, 65535));
        end
        if (faults[3]) begin
            modes[10] = WORD_CRC_BAD;
        end
        if (faults[4]) begin
            words[11] = dsrv_pkg::COMMIT_WORD ^ (32'h1 << $urandom_range(0, 31));
        end
        for (int i = 0; i < keep; i++) begin
            push_item(CMD_RECORD_WORD, (i == 11) ? commit_slot : 1'($urandom),
                      words[i], modes[i], (i == 0) ? drain : 1'b0);
        end
    endtask

    task automatic build_stimulus();
        int unsigned nrec;
        int          keep;
        bit          mid_drain;
        bit          first;
        dir_tbl = '{
            '{CMD_SCAN_END,    1'b1, 32'hFFFFFFFF, WORD_RAW, 1'b0, 1'b1, EXP_EMPTY_SCAN},
            '{CMD_RECORD_WORD, 1'b0, dsrv_pkg::MAGIC_WORD, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b1, 32'h001C0001, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b0, 32'hFFFFFFFF, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b1, 32'h00000000, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b0, 32'hFFFFFFFF, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b1, 32'h01234567, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b0, 32'h89ABCDEF, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b1, 32'h55555555, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b0, 32'hAAAAAAAA, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b1, 32'h80000001, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b0, 32'h00000000, WORD_CRC_GOOD, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b1, dsrv_pkg::COMMIT_WORD, WORD_RAW, 1'b0, 1'b1,
              EXP_TOP_VERDICT},
            '{CMD_SCAN_END,    1'b0, 32'h00000000, WORD_RAW, 1'b0, 1'b1, EXP_TOP_SCAN},
            '{CMD_RECORD_WORD, 1'b1, dsrv_pkg::MAGIC_WORD, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b0, 32'h001C0002, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_RECORD_WORD, 1'b1, 32'h12345678, WORD_RAW, 1'b0, 1'b0, EXP_NONE},
            '{CMD_SCAN_END,    1'b1, 32'h00000000, WORD_RAW, 1'b0, 1'b1, EXP_EMPTY_SCAN},
            '{CMD_SCAN_END,    1'b0, 32'hFFFFFFFF, WORD_RAW, 1'b0, 1'b1, EXP_EMPTY_SCAN}
        };
        for (int i = 0; i < DIR_ROWS; i++) begin
            stim_q.push_back(dir_tbl[i]);
        end
        mid_drain = 1'b0;
        first     = 1'b1;
        while (stim_q.size() < TOTAL_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 5)) begin
                    push_item(CMD_RECORD_WORD, 1'($urandom), rand_word(), WORD_RAW, 1'b0);
                end
            end
            case ($urandom_range(0, 9))
                0:       nrec = 0;
                1:       nrec = 1;
                8:       nrec = 3;
                9:       nrec = 4;
                default: nrec = 2;
            endcase
            for (int r = 0; r < nrec; r++) begin
                keep = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 11) : 12;
                add_record(1'($urandom), ($urandom_range(0, 2) == 0), keep, first);
                first = 1'b0;
            end
            if (!mid_drain && stim_q.size() > TOTAL_ITEMS / 2) begin
                mid_drain = 1'b1;
                push_item(CMD_SCAN_END, 1'($urandom), $urandom, WORD_RAW, 1'b1);
            end else begin
                push_item(CMD_SCAN_END, 1'($urandom), $urandom, WORD_RAW, first);
            end
            first = 1'b0;
        end
    endtask

    initial begin
        t_stim       it;
        logic [31:0] w;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned taken0;
        build_stimulus();
        burst_left = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (stim_q[n]) begin
            it = stim_q[n];
            if (it.drain) begin
                i_s_tvalid <= 1'b0;
                while (pending_q.size() != 0) @(negedge i_clk);
                repeat (DRAIN_CYCLES) @(negedge i_clk);
            end else if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 24);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            case (it.mode)
                WORD_CRC_GOOD: w = ~crc_run;
                WORD_CRC_BAD:  w = ~crc_run ^ (32'h1 << $urandom_range(0, 31));
                default:       w = it.word;
            endcase
            i_s_tvalid  <= 1'b1;
            i_s_tuser   <= it.cmd;
            i_s_tdata   <= {7'd0, w, it.slot};
            drv_has_exp <= it.has_exp;
            drv_exp     <= it.exp;
            taken0 = items_in;
            do @(negedge i_clk); while (items_in == taken0);
            if (burst_left > 0) burst_left--;
        end
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("** dual_slot_record_validator: PASSED **");
        end else begin
            $display("** dual_slot_record_validator: FAILED **");
        end
        $finish;
    end

endmodule
